// ===== design/rgb_to_hsl_pixel_defines.svh =====
// Assertion macros used by the RGB to HSL converter top level.
`ifndef RGB_TO_HSL_PIXEL_DEFINES_SVH
`define RGB_TO_HSL_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RTH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rth_pkg.sv =====
// Shared constants for the RGB to HSL converter.
`timescale 1ns / 1ps
`default_nettype none
package rth_pkg;
  localparam int CH_W    = 8;   // channel byte
  localparam int NUM_W   = 11;  // numerator and denominator, up to 6*255
  localparam int REM_W   = 12;  // partial remainder, below twice the divisor
  localparam int FIELD_W = 17;  // output field width
  localparam int LANES   = 2;   // hue, saturation
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;
  localparam logic [NUM_W-1:0] LIGHT_DEN = 11'd510;
  localparam logic [8:0]       HALF_SUM  = 9'd255;
endpackage
`default_nettype wire

// ===== design/rth_div_pipe.sv =====
// Pipelined rounding divider, two lanes plus a carried lightness, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rth_div_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                                 clk,
  input  wire logic                                                 rst,
  input  wire logic                                                 in_valid,
  output logic                                                      in_ready,
  input  wire logic [rth_pkg::LANES-1:0][rth_pkg::NUM_W-1:0]        in_num,
  input  wire logic [rth_pkg::LANES-1:0][rth_pkg::NUM_W-1:0]        in_den,
  input  wire logic [FRAC_BITS:0]                                   in_light,
  input  wire logic                                                 in_flag,
  output logic                                                      out_valid,
  input  wire logic                                                 out_ready,
  output logic [rth_pkg::LANES-1:0][FRAC_BITS:0]                    out_q,
  output logic [FRAC_BITS:0]                                        out_light,
  output logic                                                      out_flag
);
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = rth_pkg::NUM_W + FRAC_BITS + 1;
  localparam int RW = rth_pkg::REM_W;
  localparam int LN = rth_pkg::LANES;

  logic [QW:0]                       vld;
  logic [QW:0]                       en;
  logic [QW:0]                       flag;
  logic [QW-1:0]                     lt   [QW+1];
  logic [LN-1:0][rth_pkg::NUM_W-1:0] den  [QW+1];
  logic [LN-1:0][NW-1:0]             dvd  [QW+1];
  logic [LN-1:0][RW-1:0]             rem  [QW+1];
  logic [LN-1:0][QW-1:0]             quo  [QW+1];

  // Bubble-collapsing enables: a stage moves when empty or when the next moves
  assign en[QW] = !vld[QW] || out_ready;
  for (genvar k = 0; k < QW; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_ready = en[0];

  // Stage 0: form the rounded dividend and the initial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      flag[0] <= in_flag;
      lt[0]   <= in_light;
      for (int l = 0; l < LN; l++) begin
        den[0][l] <= in_den[l];
        dvd[0][l] <= (NW'(in_num[l]) << FRAC_BITS) + NW'(in_den[l] >> 1);
        rem[0][l] <= RW'((NW'(in_num[l]) << FRAC_BITS) + NW'(in_den[l] >> 1) >> QW);
        quo[0][l] <= '0;
      end
    end
  end

  // Restoring division steps, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [LN-1:0][RW-1:0] trial;
    logic [LN-1:0]         fits;

    always_comb begin
      for (int l = 0; l < LN; l++) begin
        trial[l] = {rem[k-1][l][RW-2:0], dvd[k-1][l][QW-k]};
        fits[l]  = trial[l] >= RW'(den[k-1][l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        flag[k] <= flag[k-1];
        lt[k]   <= lt[k-1];
        for (int l = 0; l < LN; l++) begin
          den[k][l] <= den[k-1][l];
          dvd[k][l] <= dvd[k-1][l];
          rem[k][l] <= fits[l] ? trial[l] - RW'(den[k-1][l]) : trial[l];
          quo[k][l] <= {quo[k-1][l][QW-2:0], fits[l]};
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_flag  = flag[QW];
  assign out_light = lt[QW];
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      out_q[l] = quo[QW][l];
    end
  end
endmodule
`default_nettype wire

// ===== design/rgb_to_hsl_pixel.sv =====
// Top level of the streaming RGB to HSL converter.
// One pixel per clock in and out while the output is not stalled. Pipeline: one input
// register, one stage that forms the dividends, FRAC_BITS + 1 divider stages
// (one quotient bit each), the last of which is the output register. Empty
// stages fill while the output is stalled. Hue, saturation and lightness are
// unsigned with FRAC_BITS fraction bits, rounded to nearest, kept to 17 bits.
// Lightness needs no divider: a byte over 255 is that byte repeated in binary,
// so it is formed up front and rides along with the divider stages.
// hue_undefined (tuser) marks black or gray pixels; hue and saturation are 0.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsl_pixel_defines.svh"
module rgb_to_hsl_pixel #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // hue[16:0], saturation[33:17], lightness[50:34], zero
  output logic             m_tuser    // hue_undefined
);
  localparam int CW = rth_pkg::CH_W;
  localparam int NU = rth_pkg::NUM_W;
  localparam int FW = rth_pkg::FIELD_W;
  localparam int LW = FRAC_BITS + 1;

  logic          va;
  logic [CW-1:0] ra, ga, ba;
  logic          div_ready;
  logic          en_a;

  // Input register
  assign en_a     = !va || div_ready;
  assign s_tready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en_a) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ra <= s_tdata[7:0];
      ga <= s_tdata[15:8];
      ba <= s_tdata[23:16];
    end
  end

  // Max, min, the two numerator/denominator pairs and the lightness
  logic [CW-1:0] v, m, d;
  logic [8:0]    sum;
  logic [NU-1:0] dn, num_h;
  logic [rth_pkg::LANES-1:0][NU-1:0] num, den;
  logic          undef;
  logic          hi;
  logic [CW-1:0] bl;
  logic [4*CW-1:0]    rep;
  logic [FRAC_BITS-1:0] pat;
  logic [LW-1:0] light_frac, light_half, light;

  always_comb begin
    v = ra;
    m = ra;
    if (ga > v) v = ga;
    if (ba > v) v = ba;
    if (ga < m) m = ga;
    if (ba < m) m = ba;
    sum   = {1'b0, v} + {1'b0, m};
    d     = v - m;
    dn    = NU'(d);
    undef = (d == '0);

    // Six-sector hue numerator
    if (ra == v) begin
      num_h = (ga == m) ? 11'd5 * dn + NU'(v - ba) : dn - NU'(v - ga);
    end else if (ga == v) begin
      num_h = (ba == m) ? dn + NU'(v - ra) : 11'd3 * dn - NU'(v - ba);
    end else begin
      num_h = (ra == m) ? 11'd3 * dn + NU'(v - ga) : 11'd5 * dn - NU'(v - ra);
    end

    num[rth_pkg::LANE_HUE]   = undef ? '0 : num_h;
    den[rth_pkg::LANE_HUE]   = undef ? NU'(1) : 11'd6 * dn;
    num[rth_pkg::LANE_SAT]   = dn;
    den[rth_pkg::LANE_SAT]   = undef ? NU'(1) :
                               (sum <= rth_pkg::HALF_SUM) ? NU'(sum) :
                               rth_pkg::LIGHT_DEN - NU'(sum);

    // Lightness sum/510: split off a whole half, rest is the byte repeated, rounded
    hi         = sum > rth_pkg::HALF_SUM;
    bl         = hi ? CW'(sum - rth_pkg::HALF_SUM) : CW'(sum);
    rep        = {4{bl}};
    pat        = rep[4*CW-1 -: FRAC_BITS];
    light_frac = ({1'b0, pat} + LW'(1)) >> 1;
    light_half = hi ? (LW'(1) << (FRAC_BITS - 1)) : '0;
    light      = light_half + light_frac;
  end

  logic [rth_pkg::LANES-1:0][FRAC_BITS:0] q;
  logic [FRAC_BITS:0]                     light_q;

  rth_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (va),
    .in_ready  (div_ready),
    .in_num    (num),
    .in_den    (den),
    .in_light  (light),
    .in_flag   (undef),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_q     (q),
    .out_light (light_q),
    .out_flag  (m_tuser)
  );

  // Pack result fields, kept to the 17-bit field width
  assign m_tdata = {5'd0,
                    FW'(light_q),
                    FW'(q[rth_pkg::LANE_SAT]),
                    FW'(q[rth_pkg::LANE_HUE])};

  // Checks
  `RTH_ASSERT_IMPL(a_undef_zero, clk, rst, m_tvalid && m_tuser, m_tdata[33:0] == '0, "hue set")
  `RTH_ASSERT_IMPL(a_stall_full, clk, rst, !s_tready, m_tvalid && !m_tready, "early stall")
  `RTH_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "hold")
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking stream testbench for the RGB to HSL pixel converter.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [rth_pkg::FIELD_W-1:0] hue;
    logic [rth_pkg::FIELD_W-1:0] sat;
    logic [rth_pkg::FIELD_W-1:0] light;
    logic                        undef;
  } hsl_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;

  hsl_t   hsl_expected[$];
  int     mismatch_cnt;
  int     src_idle_pct;
  int     snk_stall_pct;

  rgb_to_hsl_pixel #(.FRAC_BITS(16)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounded (num << 16) / den
  function automatic logic [rth_pkg::FIELD_W-1:0] div_q16(input int unsigned num,
                                                         input int unsigned den);
    longint unsigned q;
    q = ((longint'(num) << 16) + den / 2) / den;
    return q[rth_pkg::FIELD_W-1:0];
  endfunction

  function automatic hsl_t predict_hsl(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    hsl_t res;
    int unsigned v, m, sum, d, num;
    v = 32'(r); m = 32'(r);
    if (g > v) v = 32'(g);
    if (b > v) v = 32'(b);
    if (g < m) m = 32'(g);
    if (b < m) m = 32'(b);
    sum = v + m;
    d = v - m;
    res = '0;
    res.undef = 1'b1;
    if (sum != 0) begin
      res.light = div_q16(sum, 510);
      if (d != 0) begin
        res.undef = 1'b0;
        res.sat = div_q16(d, (sum <= 255) ? sum : 510 - sum);
        // six-sector hue, scaled by 6*d
        if (r == v)      num = (g == m) ? 5 * d + (v - b) : d - (v - g);
        else if (g == v) num = (b == m) ? d + (v - r) : 3 * d - (v - b);
        else             num = (r == m) ? 3 * d + (v - g) : 5 * d - (v - r);
        res.hue = div_q16(num, 6 * d);
      end
    end
    return res;
  endfunction

  // Send one pixel, with random idle cycles before it
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hsl_expected.push_back(predict_hsl(r, g, b));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (hsl_expected.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Compare each result against the oldest prediction
  always @(posedge clk) begin
    hsl_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[16:0], m_tdata[33:17], m_tdata[50:34], m_tuser};
      if (hsl_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        want = hsl_expected.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp h=%h s=%h l=%h u=%b got h=%h s=%h l=%h u=%b",
                     want.hue, want.sat, want.light, want.undef,
                     got.hue, got.sat, got.light, got.undef);
        end
      end
    end
  end

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);          // black
    send_pixel(8'd255, 8'd255, 8'd255);    // white
    send_pixel(8'd128, 8'd128, 8'd128);    // gray
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);        // pure red, hue 1.0
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd50, 8'd100);     // red max, green min
    send_pixel(8'd200, 8'd100, 8'd50);     // red max, blue min
    send_pixel(8'd50, 8'd200, 8'd100);     // green max, red min
    send_pixel(8'd100, 8'd200, 8'd50);     // green max, blue min
    send_pixel(8'd50, 8'd100, 8'd200);     // blue max, red min
    send_pixel(8'd100, 8'd50, 8'd200);     // blue max, green min
    send_pixel(8'd128, 8'd127, 8'd127);    // sum exactly at half
    send_pixel(8'd128, 8'd127, 8'd128);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd0);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    logic [7:0] r, g, b;
    src_idle_pct  = idle;
    snk_stall_pct = stall;
    repeat (count) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      // near-gray pixels exercise small d
      if ($urandom_range(3) == 0) begin
        g = 8'(r + $urandom_range(2) - 1);
        b = 8'(r + $urandom_range(2) - 1);
      end
      send_pixel(r, g, b);
    end
  endtask

  task automatic test_drain_pause();
    send_pixel(8'd10, 8'd20, 8'd30);
    wait_drained();
    send_pixel(8'd30, 8'd20, 8'd10);
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    mismatch_cnt  = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0);
    test_random(200, 86, 0);
    test_random(200, 0, 86);
    test_drain_pause();
    test_random(250, 13, 13);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && hsl_expected.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/rth_pkg.sv
design/rth_div_pipe.sv
design/rgb_to_hsl_pixel.sv
sim/tb_top.sv
